// File: rtl/tlsf_pkg.sv
// Shared types, constants and class-mapping functions for the TLSF block allocator.
// Used by tlsf_hdr_store, tlsf_seq and tlsf_block_allocator; depends on nothing.
package tlsf_pkg;

    localparam int POOL_GRANULES = 4096;
    localparam int GRANULE_BYTES = 16;
    localparam int GRAN_LOG2     = $clog2(GRANULE_BYTES);
    localparam int SL_LOG2       = 4;
    localparam int SL_COUNT      = 1 << SL_LOG2;
    localparam int FL_CLASSES    = 12;
    localparam int ADDR_W        = $clog2(POOL_GRANULES);
    localparam int LINK_W        = ADDR_W + 1;
    localparam int FL_W          = $clog2(FL_CLASSES);
    localparam int CLS_W         = FL_W + SL_LOG2;
    localparam int HEAD_DEPTH    = FL_CLASSES * SL_COUNT;
    localparam int LOOK_W        = ADDR_W + 2;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_GRANULES);

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_NOFIT   = 2'd2
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] prev_phys;
        logic [LINK_W-1:0] next_free;
        logic [LINK_W-1:0] prev_free;
        logic              live;
        logic              is_free;
        logic              prev_is_free;
    } hdr_t;

    typedef struct packed {
        logic size;
        logic prev_phys;
        logic next_free;
        logic prev_free;
        logic live;
        logic is_free;
        logic prev_is_free;
    } hdr_we_t;

    typedef struct packed {
        hdr_we_t           we;
        logic [ADDR_W-1:0] addr;
        hdr_t              data;
    } hdr_wr_t;

    typedef struct packed {
        logic              we;
        logic [CLS_W-1:0]  addr;
        logic [LINK_W-1:0] data;
    } head_wr_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] req_bytes;
        logic [3:0]  align_log2;
        logic [11:0] free_offset;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [11:0] user_offset;
    } res_t;

    typedef struct packed {
        logic            ok;
        logic [FL_W-1:0] fl;
        logic [SL_LOG2-1:0] sl;
    } cls_t;

    function automatic logic [3:0] top_bit(input logic [LOOK_W-1:0] x);
        logic [3:0] r;
        r = '0;
        for (int i = 0; i < LOOK_W; i++) begin
            if (x[i]) r = 4'(i);
        end
        return r;
    endfunction

    // Size class of a block or a search size, in granules.
    function automatic cls_t map_class(input logic [LOOK_W-1:0] size);
        cls_t              c;
        logic [3:0]        m;
        logic [LOOK_W-1:0] sh;
        logic [4:0]        f;
        m  = top_bit(size);
        sh = size >> (m - 4'(SL_LOG2));
        f  = 5'(m) - 5'(SL_LOG2) + 5'd1;
        c.ok = 1'b1;
        c.fl = '0;
        c.sl = size[SL_LOG2-1:0];
        if (size >= LOOK_W'(SL_COUNT)) begin
            if (f >= 5'(FL_CLASSES)) begin
                c.ok = 1'b0;
                c.fl = FL_W'(FL_CLASSES - 1);
                c.sl = SL_LOG2'(SL_COUNT - 1);
            end else begin
                c.fl = f[FL_W-1:0];
                c.sl = sh[SL_LOG2-1:0];
            end
        end
        return c;
    endfunction

    function automatic logic [SL_LOG2-1:0] lowest_sl(input logic [SL_COUNT-1:0] x);
        logic [SL_LOG2-1:0] r;
        r = '0;
        for (int i = SL_COUNT - 1; i >= 0; i--) begin
            if (x[i]) r = SL_LOG2'(i);
        end
        return r;
    endfunction

    function automatic logic [FL_W-1:0] lowest_fl(input logic [FL_CLASSES-1:0] x);
        logic [FL_W-1:0] r;
        r = '0;
        for (int i = FL_CLASSES - 1; i >= 0; i--) begin
            if (x[i]) r = FL_W'(i);
        end
        return r;
    endfunction

    // Header of the physically following block, held at the last granule.
    function automatic logic [ADDR_W-1:0] next_of(input logic [ADDR_W-1:0] p,
                                                  input logic [ADDR_W-1:0] size);
        logic [ADDR_W:0] s;
        s = {1'b0, p} + {1'b0, size} + (ADDR_W+1)'(1);
        return s[ADDR_W] ? ADDR_W'(POOL_GRANULES - 1) : s[ADDR_W-1:0];
    endfunction

    localparam cls_t POOL_CLS = map_class(LOOK_W'(POOL_GRANULES - 2));

endpackage

// File: rtl/tlsf_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Generic storage used by tlsf_hdr_store and the class head table.
module tlsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/tlsf_hdr_store.sv
// Block header store: one RAM per header field so each field writes on its own.
// Depends on tlsf_pkg and tlsf_ram.
module tlsf_hdr_store (
    input  logic                           aclk,
    input  tlsf_pkg::hdr_wr_t              wr,
    input  logic [tlsf_pkg::ADDR_W-1:0]    raddr,
    output tlsf_pkg::hdr_t                 rdata
);

    tlsf_ram #(.WIDTH(tlsf_pkg::ADDR_W), .DEPTH(tlsf_pkg::POOL_GRANULES)) u_size (
        .aclk(aclk), .we(wr.we.size), .waddr(wr.addr), .wdata(wr.data.size),
        .raddr(raddr), .rdata(rdata.size)
    );

    tlsf_ram #(.WIDTH(tlsf_pkg::ADDR_W), .DEPTH(tlsf_pkg::POOL_GRANULES)) u_pphys (
        .aclk(aclk), .we(wr.we.prev_phys), .waddr(wr.addr), .wdata(wr.data.prev_phys),
        .raddr(raddr), .rdata(rdata.prev_phys)
    );

    tlsf_ram #(.WIDTH(tlsf_pkg::LINK_W), .DEPTH(tlsf_pkg::POOL_GRANULES)) u_nfree (
        .aclk(aclk), .we(wr.we.next_free), .waddr(wr.addr), .wdata(wr.data.next_free),
        .raddr(raddr), .rdata(rdata.next_free)
    );

    tlsf_ram #(.WIDTH(tlsf_pkg::LINK_W), .DEPTH(tlsf_pkg::POOL_GRANULES)) u_pfree (
        .aclk(aclk), .we(wr.we.prev_free), .waddr(wr.addr), .wdata(wr.data.prev_free),
        .raddr(raddr), .rdata(rdata.prev_free)
    );

    tlsf_ram #(.WIDTH(1), .DEPTH(tlsf_pkg::POOL_GRANULES)) u_live (
        .aclk(aclk), .we(wr.we.live), .waddr(wr.addr), .wdata(wr.data.live),
        .raddr(raddr), .rdata(rdata.live)
    );

    tlsf_ram #(.WIDTH(1), .DEPTH(tlsf_pkg::POOL_GRANULES)) u_isfree (
        .aclk(aclk), .we(wr.we.is_free), .waddr(wr.addr), .wdata(wr.data.is_free),
        .raddr(raddr), .rdata(rdata.is_free)
    );

    tlsf_ram #(.WIDTH(1), .DEPTH(tlsf_pkg::POOL_GRANULES)) u_previsfree (
        .aclk(aclk), .we(wr.we.prev_is_free), .waddr(wr.addr),
        .wdata(wr.data.prev_is_free), .raddr(raddr), .rdata(rdata.prev_is_free)
    );

endmodule

// File: rtl/tlsf_seq.sv
// Request sequencer: clearing pass, class search, unlink, split, merge and relink.
// Drives the header store and class head table; depends on tlsf_pkg.
module tlsf_seq (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  tlsf_pkg::req_t                   in_req,
    input  logic                             out_free,
    output logic                             res_load,
    output tlsf_pkg::res_t                   res,
    output tlsf_pkg::hdr_wr_t                hdr_wr,
    output logic [tlsf_pkg::ADDR_W-1:0]      hdr_raddr,
    input  tlsf_pkg::hdr_t                   hdr_rdata,
    output tlsf_pkg::head_wr_t               head_wr,
    output logic [tlsf_pkg::CLS_W-1:0]       head_raddr,
    input  logic [tlsf_pkg::LINK_W-1:0]      head_rdata
);

    typedef enum logic [31:0] {
        ST_CLEAR     = 32'h0000_0001,
        ST_IDLE      = 32'h0000_0002,
        ST_A_LOOK    = 32'h0000_0004,
        ST_A_MAP     = 32'h0000_0008,
        ST_A_FIND    = 32'h0000_0010,
        ST_A_HEAD    = 32'h0000_0020,
        ST_A_ALIGN   = 32'h0000_0040,
        ST_A_GAPINS  = 32'h0000_0080,
        ST_A_TAIL    = 32'h0000_0100,
        ST_A_TAILINS = 32'h0000_0200,
        ST_A_FIN     = 32'h0000_0400,
        ST_A_FIN2    = 32'h0000_0800,
        ST_F_CHECK   = 32'h0000_1000,
        ST_F_LCHK    = 32'h0000_2000,
        ST_F_LMERGE  = 32'h0000_4000,
        ST_F_RREAD   = 32'h0000_8000,
        ST_F_RCHK    = 32'h0001_0000,
        ST_F_RMERGE  = 32'h0002_0000,
        ST_F_INS     = 32'h0004_0000,
        ST_RM0       = 32'h0008_0000,
        ST_RM1       = 32'h0010_0000,
        ST_RM2       = 32'h0020_0000,
        ST_SP0       = 32'h0040_0000,
        ST_SP1       = 32'h0080_0000,
        ST_SP2       = 32'h0100_0000,
        ST_MG0       = 32'h0200_0000,
        ST_MG1       = 32'h0400_0000,
        ST_MG2       = 32'h0800_0000,
        ST_IN0       = 32'h1000_0000,
        ST_IN1       = 32'h2000_0000,
        ST_IN2       = 32'h4000_0000,
        ST_DONE      = 32'h8000_0000
    } state_t;

    localparam int AW = tlsf_pkg::ADDR_W;
    localparam int LW = tlsf_pkg::LINK_W;
    localparam int KW = tlsf_pkg::LOOK_W;
    localparam int FW = tlsf_pkg::FL_W;
    localparam int SW = tlsf_pkg::SL_LOG2;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic [AW:0] cnt_reg, cnt_next;
    logic [tlsf_pkg::FL_CLASSES-1:0] flb_reg, flb_next;
    logic [tlsf_pkg::SL_COUNT-1:0]   slb_reg [tlsf_pkg::FL_CLASSES];
    logic [tlsf_pkg::SL_COUNT-1:0]   slb_next [tlsf_pkg::FL_CLASSES];

    tlsf_pkg::req_t req_reg, req_next;
    logic [AW:0]     want_reg, want_next;
    logic [KW-1:0]   look_reg, look_next;
    logic [tlsf_pkg::CLS_W-1:0] cls_reg, cls_next;
    logic [AW-1:0]   p_reg, p_next, psize_reg, psize_next;
    logic [AW-1:0]   x_reg, x_next, xsize_reg, xsize_next;
    logic [AW-1:0]   r_reg, r_next, rsize_reg, rsize_next, keep_reg, keep_next;
    logic [AW-1:0]   q_reg, q_next;
    logic [LW-1:0]   nx_reg, nx_next, pr_reg, pr_next;
    logic            pfree_reg, pfree_next;
    tlsf_pkg::status_t status_reg, status_next;
    logic [AW-1:0]   uoff_reg, uoff_next;

    // Alignment helpers shared by the search size and the gap trim.
    logic            big_align;
    logic [3:0]      k_sh;
    logic [AW-1:0]   ag;
    logic [16:0]     req_rnd;
    logic [KW-1:0]   base_sum, look_al, lk, rnd, gap_sum, al, gap, ucat;
    logic [3:0]      m_top;
    tlsf_pkg::cls_t  mc;
    logic [tlsf_pkg::SL_COUNT-1:0]   sbm;
    logic [tlsf_pkg::FL_CLASSES-1:0] fbm;
    logic [FW-1:0]   fl_a, fl_b;
    logic [SW-1:0]   sl_a;
    logic [AW-1:0]   nb;
    logic [tlsf_pkg::SL_COUNT-1:0]   slb_row;

    assign big_align = req_reg.align_log2 > 4'(tlsf_pkg::GRAN_LOG2);
    assign k_sh      = req_reg.align_log2 - 4'(tlsf_pkg::GRAN_LOG2);
    assign ag        = AW'(1) << k_sh;
    assign in_ready  = (state_reg == ST_IDLE);
    assign res.status      = status_reg;
    assign res.user_offset = uoff_reg;

    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        cnt_next    = cnt_reg;
        flb_next    = flb_reg;
        slb_next    = slb_reg;
        req_next    = req_reg;
        want_next   = want_reg;
        look_next   = look_reg;
        cls_next    = cls_reg;
        p_next      = p_reg;
        psize_next  = psize_reg;
        x_next      = x_reg;
        xsize_next  = xsize_reg;
        r_next      = r_reg;
        rsize_next  = rsize_reg;
        keep_next   = keep_reg;
        q_next      = q_reg;
        nx_next     = nx_reg;
        pr_next     = pr_reg;
        pfree_next  = pfree_reg;
        status_next = status_reg;
        uoff_next   = uoff_reg;
        res_load    = 1'b0;
        hdr_wr      = '0;
        hdr_raddr   = '0;
        head_wr     = '0;
        head_raddr  = '0;
        req_rnd  = '0;
        base_sum = '0;
        look_al  = '0;
        lk       = '0;
        rnd      = '0;
        gap_sum  = '0;
        al       = '0;
        gap      = '0;
        ucat     = '0;
        m_top    = '0;
        mc       = '0;
        sbm      = '0;
        fbm      = '0;
        fl_a     = '0;
        fl_b     = '0;
        sl_a     = '0;
        nb       = '0;
        slb_row  = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                // Zero every header, seed pool block, end marker and class heads.
                hdr_wr.we   = '1;
                hdr_wr.addr = cnt_reg[AW-1:0];
                if (cnt_reg[AW-1:0] == '0) begin
                    hdr_wr.data.size      = AW'(tlsf_pkg::POOL_GRANULES - 2);
                    hdr_wr.data.next_free = tlsf_pkg::NIL;
                    hdr_wr.data.prev_free = tlsf_pkg::NIL;
                    hdr_wr.data.live      = 1'b1;
                    hdr_wr.data.is_free   = 1'b1;
                end else if (cnt_reg[AW-1:0] == AW'(tlsf_pkg::POOL_GRANULES - 1)) begin
                    hdr_wr.data.live         = 1'b1;
                    hdr_wr.data.prev_is_free = 1'b1;
                end
                if (cnt_reg < (AW+1)'(tlsf_pkg::HEAD_DEPTH)) begin
                    head_wr.we   = 1'b1;
                    head_wr.addr = cnt_reg[tlsf_pkg::CLS_W-1:0];
                    head_wr.data = (cnt_reg[tlsf_pkg::CLS_W-1:0] ==
                                    {tlsf_pkg::POOL_CLS.fl, tlsf_pkg::POOL_CLS.sl})
                                   ? '0 : tlsf_pkg::NIL;
                end
                cnt_next = cnt_reg + (AW+1)'(1);
                if (cnt_reg[AW-1:0] == AW'(tlsf_pkg::POOL_GRANULES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                hdr_raddr = in_req.free_offset - AW'(1);
                if (in_valid) begin
                    req_next  = in_req;
                    p_next    = in_req.free_offset - AW'(1);
                    uoff_next = '0;
                    state_next = in_req.mode ? ST_F_CHECK : ST_A_LOOK;
                end
            end
            ST_A_LOOK: begin
                req_rnd  = {1'b0, req_reg.req_bytes} + 17'(tlsf_pkg::GRANULE_BYTES - 1);
                want_next = req_rnd[16:tlsf_pkg::GRAN_LOG2];
                base_sum = KW'(req_rnd[16:tlsf_pkg::GRAN_LOG2]) + KW'(2) + KW'(ag) + KW'(ag)
                           - KW'(1);
                look_al  = (base_sum >> k_sh) << k_sh;
                look_next = big_align ? look_al : KW'(req_rnd[16:tlsf_pkg::GRAN_LOG2]);
                if (req_reg.req_bytes == '0) begin
                    status_next = tlsf_pkg::STAT_IGNORED;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_A_MAP;
                end
            end
            ST_A_MAP: begin
                // Round the search size up to the next class boundary.
                m_top = tlsf_pkg::top_bit(look_reg);
                rnd   = (KW'(1) << (m_top - 4'(SW))) - KW'(1);
                lk    = (look_reg >= KW'(tlsf_pkg::SL_COUNT)) ? look_reg + rnd : look_reg;
                mc    = tlsf_pkg::map_class(lk);
                cls_next = {mc.fl, mc.sl};
                if (!mc.ok) begin
                    status_next = tlsf_pkg::STAT_NOFIT;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_A_FIND;
                end
            end
            ST_A_FIND: begin
                fl_a = cls_reg[tlsf_pkg::CLS_W-1:SW];
                sbm  = slb_reg[fl_a] & ({tlsf_pkg::SL_COUNT{1'b1}} << cls_reg[SW-1:0]);
                fbm  = ((5'(fl_a) + 5'd1) < 5'(tlsf_pkg::FL_CLASSES))
                       ? flb_reg & ({tlsf_pkg::FL_CLASSES{1'b1}} << (5'(fl_a) + 5'd1))
                       : '0;
                fl_b = tlsf_pkg::lowest_fl(fbm);
                if (sbm != '0) begin
                    sl_a       = tlsf_pkg::lowest_sl(sbm);
                    cls_next   = {fl_a, sl_a};
                    head_raddr = {fl_a, sl_a};
                    state_next = ST_A_HEAD;
                end else if (fbm == '0 || slb_reg[fl_b] == '0) begin
                    status_next = tlsf_pkg::STAT_NOFIT;
                    state_next  = ST_DONE;
                end else begin
                    sl_a       = tlsf_pkg::lowest_sl(slb_reg[fl_b]);
                    cls_next   = {fl_b, sl_a};
                    head_raddr = {fl_b, sl_a};
                    state_next = ST_A_HEAD;
                end
            end
            ST_A_HEAD: begin
                if (head_rdata[AW]) begin
                    status_next = tlsf_pkg::STAT_NOFIT;
                    state_next  = ST_DONE;
                end else begin
                    p_next     = head_rdata[AW-1:0];
                    x_next     = head_rdata[AW-1:0];
                    ret_next   = ST_A_ALIGN;
                    state_next = ST_RM0;
                end
            end
            ST_A_ALIGN: begin
                // Trim a leading gap so the user area lands on the alignment.
                psize_next = xsize_reg;
                ucat    = KW'(p_reg) + KW'(1);
                gap_sum = ucat + KW'(ag) - KW'(1);
                al      = (gap_sum >> k_sh) << k_sh;
                gap     = al - ucat;
                if (gap == KW'(1)) begin
                    gap = gap + KW'(ag);
                end
                keep_next = gap[AW-1:0] - AW'(1);
                if (big_align && gap != '0 && KW'(xsize_reg) >= gap + KW'(1)) begin
                    ret_next   = ST_A_GAPINS;
                    state_next = ST_SP0;
                end else begin
                    state_next = ST_A_TAIL;
                end
            end
            ST_A_GAPINS: begin
                x_next     = p_reg;
                xsize_next = psize_reg;
                p_next     = r_reg;
                psize_next = rsize_reg;
                ret_next   = ST_A_TAIL;
                state_next = ST_IN0;
            end
            ST_A_TAIL: begin
                keep_next = want_reg[AW-1:0];
                if (KW'(psize_reg) >= KW'(want_reg) + KW'(2)) begin
                    ret_next   = ST_A_TAILINS;
                    state_next = ST_SP0;
                end else begin
                    state_next = ST_A_FIN;
                end
            end
            ST_A_TAILINS: begin
                x_next     = r_reg;
                xsize_next = rsize_reg;
                ret_next   = ST_A_FIN;
                state_next = ST_IN0;
            end
            ST_A_FIN: begin
                hdr_wr.addr            = tlsf_pkg::next_of(p_reg, psize_reg);
                hdr_wr.we.prev_is_free = 1'b1;
                state_next = ST_A_FIN2;
            end
            ST_A_FIN2: begin
                hdr_wr.addr       = p_reg;
                hdr_wr.we.is_free = 1'b1;
                status_next = tlsf_pkg::STAT_OK;
                uoff_next   = p_reg + AW'(1);
                state_next  = ST_DONE;
            end
            ST_F_CHECK: begin
                if (req_reg.free_offset == '0 || !hdr_rdata.live || hdr_rdata.is_free ||
                    hdr_rdata.size == '0) begin
                    status_next = tlsf_pkg::STAT_IGNORED;
                    state_next  = ST_DONE;
                end else begin
                    psize_next = hdr_rdata.size;
                    pfree_next = hdr_rdata.prev_is_free;
                    q_next     = hdr_rdata.prev_phys;
                    hdr_wr.addr = tlsf_pkg::next_of(p_reg, hdr_rdata.size);
                    hdr_wr.we.prev_is_free   = 1'b1;
                    hdr_wr.we.prev_phys      = 1'b1;
                    hdr_wr.data.prev_is_free = 1'b1;
                    hdr_wr.data.prev_phys    = p_reg;
                    hdr_raddr  = hdr_rdata.prev_phys;
                    state_next = ST_F_LCHK;
                end
            end
            ST_F_LCHK: begin
                hdr_wr.addr         = p_reg;
                hdr_wr.we.is_free   = 1'b1;
                hdr_wr.data.is_free = 1'b1;
                if (pfree_reg && q_reg < p_reg && hdr_rdata.live && hdr_rdata.is_free) begin
                    x_next     = q_reg;
                    ret_next   = ST_F_LMERGE;
                    state_next = ST_RM0;
                end else begin
                    state_next = ST_F_RREAD;
                end
            end
            ST_F_LMERGE: begin
                // The free neighbor below becomes the surviving block.
                p_next     = x_reg;
                x_next     = p_reg;
                psize_next = xsize_reg;
                xsize_next = psize_reg;
                ret_next   = ST_F_RREAD;
                state_next = ST_MG0;
            end
            ST_F_RREAD: begin
                nb         = tlsf_pkg::next_of(p_reg, psize_reg);
                hdr_raddr  = nb;
                x_next     = nb;
                state_next = ST_F_RCHK;
            end
            ST_F_RCHK: begin
                if (x_reg != p_reg && hdr_rdata.live && hdr_rdata.is_free) begin
                    ret_next   = ST_F_RMERGE;
                    state_next = ST_RM0;
                end else begin
                    state_next = ST_F_INS;
                end
            end
            ST_F_RMERGE: begin
                ret_next   = ST_F_INS;
                state_next = ST_MG0;
            end
            ST_F_INS: begin
                x_next      = p_reg;
                xsize_next  = psize_reg;
                status_next = tlsf_pkg::STAT_OK;
                ret_next    = ST_DONE;
                state_next  = ST_IN0;
            end
            ST_RM0: begin
                hdr_raddr  = x_reg;
                state_next = ST_RM1;
            end
            ST_RM1: begin
                mc          = tlsf_pkg::map_class(KW'(hdr_rdata.size));
                cls_next    = {mc.fl, mc.sl};
                head_raddr  = {mc.fl, mc.sl};
                xsize_next  = hdr_rdata.size;
                nx_next     = hdr_rdata.next_free;
                pr_next     = hdr_rdata.prev_free;
                hdr_wr.addr = hdr_rdata.next_free[AW-1:0];
                hdr_wr.we.prev_free   = !hdr_rdata.next_free[AW];
                hdr_wr.data.prev_free = hdr_rdata.prev_free;
                state_next = ST_RM2;
            end
            ST_RM2: begin
                fl_a = cls_reg[tlsf_pkg::CLS_W-1:SW];
                hdr_wr.addr           = pr_reg[AW-1:0];
                hdr_wr.we.next_free   = !pr_reg[AW];
                hdr_wr.data.next_free = nx_reg;
                if (head_rdata == {1'b0, x_reg}) begin
                    head_wr.we   = 1'b1;
                    head_wr.addr = cls_reg;
                    head_wr.data = nx_reg;
                    if (nx_reg[AW]) begin
                        slb_row = slb_reg[fl_a];
                        slb_row[cls_reg[SW-1:0]] = 1'b0;
                        slb_next[fl_a] = slb_row;
                        if (slb_row == '0) begin
                            flb_next[fl_a] = 1'b0;
                        end
                    end
                end
                state_next = ret_reg;
            end
            ST_SP0: begin
                r_next     = p_reg + keep_reg + AW'(1);
                rsize_next = psize_reg - keep_reg - AW'(1);
                hdr_wr.we  = '1;
                hdr_wr.addr = p_reg + keep_reg + AW'(1);
                hdr_wr.data.size         = psize_reg - keep_reg - AW'(1);
                hdr_wr.data.prev_phys    = p_reg;
                hdr_wr.data.live         = 1'b1;
                hdr_wr.data.is_free      = 1'b1;
                hdr_wr.data.prev_is_free = 1'b1;
                state_next = ST_SP1;
            end
            ST_SP1: begin
                hdr_wr.addr      = p_reg;
                hdr_wr.we.size   = 1'b1;
                hdr_wr.data.size = keep_reg;
                psize_next = keep_reg;
                state_next = ST_SP2;
            end
            ST_SP2: begin
                hdr_wr.addr = tlsf_pkg::next_of(r_reg, rsize_reg);
                hdr_wr.we.prev_phys      = 1'b1;
                hdr_wr.we.prev_is_free   = 1'b1;
                hdr_wr.data.prev_phys    = r_reg;
                hdr_wr.data.prev_is_free = 1'b1;
                state_next = ret_reg;
            end
            ST_MG0: begin
                hdr_wr.addr      = p_reg;
                hdr_wr.we.size   = 1'b1;
                hdr_wr.data.size = psize_reg + xsize_reg + AW'(1);
                psize_next = psize_reg + xsize_reg + AW'(1);
                state_next = ST_MG1;
            end
            ST_MG1: begin
                hdr_wr.addr = x_reg;
                hdr_wr.we   = '1;
                state_next  = ST_MG2;
            end
            ST_MG2: begin
                hdr_wr.addr = tlsf_pkg::next_of(p_reg, psize_reg);
                hdr_wr.we.prev_phys   = 1'b1;
                hdr_wr.data.prev_phys = p_reg;
                state_next = ret_reg;
            end
            ST_IN0: begin
                mc         = tlsf_pkg::map_class(KW'(xsize_reg));
                cls_next   = {mc.fl, mc.sl};
                head_raddr = {mc.fl, mc.sl};
                state_next = ST_IN1;
            end
            ST_IN1: begin
                fl_a = cls_reg[tlsf_pkg::CLS_W-1:SW];
                nx_next = head_rdata;
                hdr_wr.addr = x_reg;
                hdr_wr.we.next_free   = 1'b1;
                hdr_wr.we.prev_free   = 1'b1;
                hdr_wr.data.next_free = head_rdata;
                hdr_wr.data.prev_free = tlsf_pkg::NIL;
                head_wr.we   = 1'b1;
                head_wr.addr = cls_reg;
                head_wr.data = {1'b0, x_reg};
                slb_row = slb_reg[fl_a];
                slb_row[cls_reg[SW-1:0]] = 1'b1;
                slb_next[fl_a] = slb_row;
                flb_next[fl_a] = 1'b1;
                state_next = ST_IN2;
            end
            ST_IN2: begin
                hdr_wr.addr           = nx_reg[AW-1:0];
                hdr_wr.we.prev_free   = !nx_reg[AW];
                hdr_wr.data.prev_free = {1'b0, x_reg};
                state_next = ret_reg;
            end
            ST_DONE: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ret_reg   <= ST_IDLE;
            cnt_reg   <= '0;
            flb_reg   <= '0;
            flb_reg[tlsf_pkg::POOL_CLS.fl] <= 1'b1;
            for (int i = 0; i < tlsf_pkg::FL_CLASSES; i++) begin
                slb_reg[i] <= '0;
            end
            slb_reg[tlsf_pkg::POOL_CLS.fl][tlsf_pkg::POOL_CLS.sl] <= 1'b1;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
            flb_reg   <= flb_next;
            slb_reg   <= slb_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        want_reg   <= want_next;
        look_reg   <= look_next;
        cls_reg    <= cls_next;
        p_reg      <= p_next;
        psize_reg  <= psize_next;
        x_reg      <= x_next;
        xsize_reg  <= xsize_next;
        r_reg      <= r_next;
        rsize_reg  <= rsize_next;
        keep_reg   <= keep_next;
        q_reg      <= q_next;
        nx_reg     <= nx_next;
        pr_reg     <= pr_next;
        pfree_reg  <= pfree_next;
        status_reg <= status_next;
        uoff_reg   <= uoff_next;
    end

endmodule

// File: rtl/tlsf_block_allocator.sv
// Top level of the TLSF block allocator: stream ports, result register, storage.
// Depends on tlsf_pkg, tlsf_ram, tlsf_hdr_store and tlsf_seq.
//
//   Group   Direction  Carries
//   s_*     in         one request item: mode in tuser, size/alignment/offset in tdata
//   m_*     out        one result item: status in tuser, user offset in tdata
//
// After reset the block sweeps all 4096 header entries (and the 192 class heads
// on the way), so it is not ready until the sweep ends.
// An allocate and a free each run as a sequence of header RAM accesses: one
// header write and one read per cycle.
// The block takes one item at a time; a finished result waits in the output
// register and the next item is accepted while it waits.
module tlsf_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // req_bytes[15:0], align_log2[19:16], free_offset[31:20]
    input  logic [0:0]  s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // user_offset[11:0], zero fill[15:12]
    output logic [1:0]  m_tuser    // status[1:0]
);

    tlsf_pkg::req_t    in_req;
    tlsf_pkg::res_t    res;
    tlsf_pkg::res_t    m_res_reg;
    logic              m_valid_reg;
    logic              res_load;
    logic              out_free;
    tlsf_pkg::hdr_wr_t hdr_wr;
    tlsf_pkg::hdr_t    hdr_rdata;
    logic [tlsf_pkg::ADDR_W-1:0] hdr_raddr;
    tlsf_pkg::head_wr_t head_wr;
    logic [tlsf_pkg::CLS_W-1:0]  head_raddr;
    logic [tlsf_pkg::LINK_W-1:0] head_rdata;

    assign in_req.mode        = s_tuser[0];
    assign in_req.req_bytes   = s_tdata[15:0];
    assign in_req.align_log2  = s_tdata[19:16];
    assign in_req.free_offset = s_tdata[31:20];

    // The result register frees up in the same cycle its item is taken.
    assign out_free = !m_valid_reg || m_tready;

    tlsf_seq u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
        .out_free(out_free), .res_load(res_load), .res(res),
        .hdr_wr(hdr_wr), .hdr_raddr(hdr_raddr), .hdr_rdata(hdr_rdata),
        .head_wr(head_wr), .head_raddr(head_raddr), .head_rdata(head_rdata)
    );

    tlsf_hdr_store u_hdr (
        .aclk(aclk), .wr(hdr_wr), .raddr(hdr_raddr), .rdata(hdr_rdata)
    );

    tlsf_ram #(.WIDTH(tlsf_pkg::LINK_W), .DEPTH(tlsf_pkg::HEAD_DEPTH)) u_heads (
        .aclk(aclk), .we(head_wr.we), .waddr(head_wr.addr), .wdata(head_wr.data),
        .raddr(head_raddr), .rdata(head_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_res_reg.user_offset};
    assign m_tuser  = m_res_reg.status;

`ifndef SYNTHESIS
    // A result other than OK never carries a user offset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != tlsf_pkg::STAT_OK) |-> (m_tdata == '0))
        else $error("nonzero offset with failing status");

    // Ready drops in the cycle after an item is accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted on back-to-back cycles");

    // The clearing sweep keeps the block closed right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("ready during clearing sweep");
`endif

endmodule
